FILE: hdl/eight_axis_servo_jog_controller_top_macros.svh
// ----------------------------------------------------------------------------
// servo jog controller assertion macros
// shared assertion forms used by the jog controller rtl
// ----------------------------------------------------------------------------
`ifndef EIGHT_AXIS_SERVO_JOG_CONTROLLER_TOP_MACROS_SVH
`define EIGHT_AXIS_SERVO_JOG_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define SJC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SJC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sjc_pkg.sv
// ----------------------------------------------------------------------------
// servo jog controller package
// types, constants and codes shared by the jog controller modules
// ----------------------------------------------------------------------------
package sjc_pkg;

  localparam int SERVO_COUNT         = 8;
  localparam int UPDATE_PERIOD_TICKS = 20;
  localparam int POSITION_BITS       = 10;

  localparam int N_SERVOS  = 8;
  localparam int IDX_W     = 3;
  localparam int PACK_BITS = 10;
  localparam int PACK_W    = 40;
  localparam int VEL_W     = 8;
  localparam int STEP_W    = 7;
  localparam int TICK_W    = 16;

  localparam logic [7:0] STICK_NEG_MAX = 8'd108;
  localparam logic [7:0] STICK_POS_MIN = 8'd148;

  localparam logic [PACK_BITS-1:0] POS_MASK = PACK_BITS'((1 << POSITION_BITS) - 1);

  localparam logic [PACK_W-1:0] LOWER_RESET = '0;
  localparam logic [PACK_W-1:0] UPPER_RESET = {4{10'd1000}};
  localparam logic [PACK_W-1:0] HOME_RESET  = {4{10'd500}};
  localparam logic [STEP_W-1:0] STEP_RESET  = 7'd10;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_HOME   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CFG_LOWER_A = 3'd0,
    CFG_LOWER_B = 3'd1,
    CFG_UPPER_A = 3'd2,
    CFG_UPPER_B = 3'd3,
    CFG_HOME_A  = 3'd4,
    CFG_HOME_B  = 3'd5,
    CFG_REVERSE = 3'd6,
    CFG_STEP    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] stick_lx;
    logic [7:0] stick_ly;
    logic [7:0] stick_rx;
    logic [7:0] stick_ry;
    logic [7:0] buttons;
  } in_word_t;

  typedef struct packed {
    logic [3:0] servo_id;
    logic [9:0] position;
    logic       last;
  } out_word_t;

  typedef logic [N_SERVOS-1:0][VEL_W-1:0] vel_vec_t;

  typedef struct packed {
    logic [PACK_BITS-1:0] new_pos;
    logic                 hold;
  } step_res_t;

endpackage

FILE: hdl/sjc_jog_map.sv
// ----------------------------------------------------------------------------
// servo jog controller velocity map
// turns one gamepad word into a signed velocity for each servo
// ----------------------------------------------------------------------------
module sjc_jog_map import sjc_pkg::*; (
  input  in_word_t          pad,
  input  logic [7:0]        reverse,
  input  logic [STEP_W-1:0] step,
  output vel_vec_t          vel
);

  logic [N_SERVOS-1:0] move;
  logic [N_SERVOS-1:0] minus;
  logic [VEL_W-1:0]    step_pos;
  logic [VEL_W-1:0]    step_neg;

  always_comb begin
    move[0]  = (pad.stick_lx <= STICK_NEG_MAX) || (pad.stick_lx >= STICK_POS_MIN);
    minus[0] = pad.stick_lx <= STICK_NEG_MAX;
    move[1]  = (pad.stick_ly <= STICK_NEG_MAX) || (pad.stick_ly >= STICK_POS_MIN);
    minus[1] = pad.stick_ly <= STICK_NEG_MAX;
    move[2]  = (pad.stick_rx <= STICK_NEG_MAX) || (pad.stick_rx >= STICK_POS_MIN);
    minus[2] = pad.stick_rx <= STICK_NEG_MAX;
    move[3]  = (pad.stick_ry <= STICK_NEG_MAX) || (pad.stick_ry >= STICK_POS_MIN);
    minus[3] = pad.stick_ry <= STICK_NEG_MAX;
    // first button of each pair wins
    move[4]  = pad.buttons[0] || pad.buttons[1];
    minus[4] = pad.buttons[0];
    move[5]  = pad.buttons[2] || pad.buttons[3];
    minus[5] = pad.buttons[2];
    move[6]  = pad.buttons[4] || pad.buttons[5];
    minus[6] = pad.buttons[4];
    move[7]  = pad.buttons[6] || pad.buttons[7];
    minus[7] = !pad.buttons[6];
  end

  assign step_pos = {1'b0, step};
  assign step_neg = VEL_W'(0) - step_pos;

  always_comb begin
    for (int i = 0; i < N_SERVOS; i++) begin
      if (!move[i]) begin
        vel[i] = '0;
      end else if (minus[i] ^ reverse[i]) begin
        vel[i] = step_neg;
      end else begin
        vel[i] = step_pos;
      end
    end
  end

endmodule

FILE: hdl/sjc_step_unit.sv
// ----------------------------------------------------------------------------
// servo jog controller step unit
// shared add and clamp used once per servo during an update
// ----------------------------------------------------------------------------
module sjc_step_unit import sjc_pkg::*; (
  input  logic [PACK_BITS-1:0] pos,
  input  logic [VEL_W-1:0]     vel,
  input  logic [PACK_BITS-1:0] lo,
  input  logic [PACK_BITS-1:0] hi,
  output step_res_t            res
);

  logic signed [PACK_BITS+1:0] sum;
  logic signed [PACK_BITS+1:0] lo_s;
  logic signed [PACK_BITS+1:0] hi_s;
  logic signed [PACK_BITS+1:0] clamped;

  assign sum  = $signed({2'b00, pos}) + $signed({{(PACK_BITS+2-VEL_W){vel[VEL_W-1]}}, vel});
  assign lo_s = $signed({2'b00, lo});
  assign hi_s = $signed({2'b00, hi});

  always_comb begin
    if (sum < lo_s) begin
      clamped = lo_s;
    end else if (sum > hi_s) begin
      clamped = hi_s;
    end else begin
      clamped = sum;
    end
  end

  // clamped always lands in the unsigned position range
  assign res.new_pos = clamped[PACK_BITS-1:0];
  assign res.hold    = clamped[PACK_BITS-1:0] == pos;

endmodule

FILE: hdl/eight_axis_servo_jog_controller_top.sv
// Gamepad and home words are taken in the idle state and in_ready stays high.
// A tick word is taken the same way; when the update interval ends, in_ready drops while
// the single shared add and clamp unit steps through each servo (SERVO_COUNT) in turn,
// then results leave one per cycle while out_ready is high, with each skipped servo
// below the last mover passed over in turn and a closing step before in_ready returns.
// Synchronous active-low reset clears servo state and tick count, restores registers.
// ----------------------------------------------------------------------------
// servo jog controller top level
// config registers, servo state, update sequencer and result channel
// ----------------------------------------------------------------------------
`include "eight_axis_servo_jog_controller_top_macros.svh"

module eight_axis_servo_jog_controller_top import sjc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [PACK_W-1:0] cfg_data
);

  logic [PACK_W-1:0] lower_a_r, lower_b_r, upper_a_r, upper_b_r, home_a_r, home_b_r;
  logic [7:0]        reverse_r;
  logic [STEP_W-1:0] step_r;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [N_SERVOS-1:0]      mask_r, mask_nxt;
  logic [TICK_W-1:0]        elapsed_r, elapsed_nxt;
  logic [PACK_BITS-1:0]     pos_r   [N_SERVOS];
  logic [PACK_BITS-1:0]     pos_nxt [N_SERVOS];
  vel_vec_t                 vel_r, vel_nxt;

  vel_vec_t                 pad_vel;
  step_res_t                step_res;
  logic [2*PACK_W-1:0]      lo_vec, hi_vec, home_vec;
  logic [PACK_BITS-1:0]     cur_lo, cur_hi;
  logic [TICK_W-1:0]        elapsed_inc;
  logic                     in_fire;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_a_r <= LOWER_RESET;
      lower_b_r <= LOWER_RESET;
      upper_a_r <= UPPER_RESET;
      upper_b_r <= UPPER_RESET;
      home_a_r  <= HOME_RESET;
      home_b_r  <= HOME_RESET;
      reverse_r <= '0;
      step_r    <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER_A: lower_a_r <= cfg_data;
        CFG_LOWER_B: lower_b_r <= cfg_data;
        CFG_UPPER_A: upper_a_r <= cfg_data;
        CFG_UPPER_B: upper_b_r <= cfg_data;
        CFG_HOME_A:  home_a_r  <= cfg_data;
        CFG_HOME_B:  home_b_r  <= cfg_data;
        CFG_REVERSE: reverse_r <= cfg_data[7:0];
        CFG_STEP:    step_r    <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sjc_jog_map u_jog_map (
    .pad     (in_data),
    .reverse (reverse_r),
    .step    (step_r),
    .vel     (pad_vel)
  );

  assign lo_vec   = {lower_b_r, lower_a_r};
  assign hi_vec   = {upper_b_r, upper_a_r};
  assign home_vec = {home_b_r, home_a_r};
  assign cur_lo   = lo_vec[idx_r*PACK_BITS +: PACK_BITS];
  assign cur_hi   = hi_vec[idx_r*PACK_BITS +: PACK_BITS];

  sjc_step_unit u_step_unit (
    .pos (pos_r[idx_r]),
    .vel (vel_r[idx_r]),
    .lo  (cur_lo),
    .hi  (cur_hi),
    .res (step_res)
  );

  assign in_ready    = state_r == ST_IDLE;
  assign in_fire     = in_valid && in_ready;
  assign elapsed_inc = elapsed_r + TICK_W'(1);

  assign out_data.servo_id = {1'b0, idx_r} + 4'd1;
  assign out_data.position = pos_r[idx_r];
  assign out_data.last     = (mask_r & ~(N_SERVOS'(1) << idx_r)) == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      mask_r    <= '0;
      elapsed_r <= '0;
      vel_r     <= '0;
      for (int i = 0; i < N_SERVOS; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      mask_r    <= mask_nxt;
      elapsed_r <= elapsed_nxt;
      vel_r     <= vel_nxt;
      pos_r     <= pos_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    mask_nxt    = mask_r;
    elapsed_nxt = elapsed_r;
    vel_nxt     = vel_r;
    pos_nxt     = pos_r;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.kind)
            KIND_SAMPLE: vel_nxt = pad_vel;
            KIND_HOME: begin
              vel_nxt = '0;
              for (int i = 0; i < N_SERVOS; i++) begin
                pos_nxt[i] = home_vec[i*PACK_BITS +: PACK_BITS];
              end
            end
            KIND_TICK: begin
              if (elapsed_inc >= TICK_W'(UPDATE_PERIOD_TICKS)) begin
                elapsed_nxt = '0;
                idx_nxt     = '0;
                mask_nxt    = '0;
                state_nxt   = ST_CALC;
              end else begin
                elapsed_nxt = elapsed_inc;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CALC: begin
        if (vel_r[idx_r] != '0) begin
          if (step_res.hold) begin
            vel_nxt[idx_r] = '0;
          end else begin
            pos_nxt[idx_r]  = step_res.new_pos & POS_MASK;
            mask_nxt[idx_r] = 1'b1;
          end
        end
        if (idx_r == IDX_W'(SERVO_COUNT - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (mask_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (mask_r[idx_r]) begin
          out_valid = 1'b1;
          if (out_ready) begin
            mask_nxt[idx_r] = 1'b0;
            idx_nxt         = idx_r + IDX_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `SJC_ASSERT_NOW(a_out_only_in_emit, out_valid, state_r == ST_EMIT && !in_ready, "word offered outside emit")
  `SJC_ASSERT_NEXT(a_out_pops_mask, out_valid && out_ready, $countones(mask_r) == $countones($past(mask_r)) - 1, "accepted word did not retire one servo")
  `SJC_ASSERT_NOW(a_tick_bound, 1'b1, elapsed_r < TICK_W'(UPDATE_PERIOD_TICKS), "tick count past update period")
  `SJC_ASSERT_NEXT(a_calc_starts_clear, state_r == ST_IDLE && state_nxt == ST_CALC, mask_r == '0 && idx_r == '0, "update started with stale mover set")

endmodule

FILE: tb/eight_axis_servo_jog_controller_top_test.sv
// ----------------------------------------------------------------------------
// servo jog controller testbench
// Drives gamepad, tick, home and unused words through the input channel. A
// built-in predictor of the velocity mapping and the periodic update works
// out the servo moves that each accepted word causes. Every result word is
// checked against them in order, with both channels stalling at random in most
// phases, across default, random, extreme and crossed-limit register settings.
// ----------------------------------------------------------------------------
module eight_axis_servo_jog_controller_top_test import sjc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam int         STICK_CENTRE   = 128;
  localparam int         DEAD_BAND      = 20;
  localparam int         SETTLE_CYCLES  = 2 * SERVO_COUNT + 8;
  localparam int         QUIET_LIMIT    = 20000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [PACK_W-1:0] cfg_data  = '0;

  in_word_t  pending_words[$];
  out_word_t expected_moves[$];
  logic      in_fire        = 1'b0;
  int        send_idle_pct  = 20;
  int        recv_idle_pct  = 65;
  int        words_queued   = 0;
  int        words_taken    = 0;
  int        items_queued   = 0;
  int        failures       = 0;

  // predictor state and register copies
  logic [PACK_W-1:0] lower_a   = LOWER_RESET;
  logic [PACK_W-1:0] lower_b   = LOWER_RESET;
  logic [PACK_W-1:0] upper_a   = UPPER_RESET;
  logic [PACK_W-1:0] upper_b   = UPPER_RESET;
  logic [PACK_W-1:0] home_a    = HOME_RESET;
  logic [PACK_W-1:0] home_b    = HOME_RESET;
  logic [7:0]        rev_mask  = '0;
  logic [STEP_W-1:0] step_size = STEP_RESET;
  int                servo_pos[N_SERVOS] = '{default: 0};
  int                servo_vel[N_SERVOS] = '{default: 0};
  int                tick_count = 0;

  eight_axis_servo_jog_controller_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pos_field(logic [PACK_W-1:0] first4, logic [PACK_W-1:0] last4,
                                   int i);
    logic [PACK_W-1:0] w;
    w = (i < 4) ? first4 : last4;
    return int'(w[(i % 4) * PACK_BITS +: PACK_BITS]);
  endfunction

  function automatic int dir_of(int i);
    return rev_mask[i] ? -1 : 1;
  endfunction

  function automatic int stick_rate(logic [7:0] raw, int i);
    int s;
    s = int'(raw) - STICK_CENTRE;
    if (s > -DEAD_BAND && s < DEAD_BAND) return 0;
    return (s > 0 ? 1 : -1) * dir_of(i) * int'(step_size);
  endfunction

  function automatic int pair_rate(logic first, logic second, int first_sign, int i);
    int step;
    step = dir_of(i) * int'(step_size);
    if (first) return first_sign * step;
    if (second) return -first_sign * step;
    return 0;
  endfunction

  task automatic predict_moves(input in_word_t w);
    out_word_t m;
    int        i, np, lo, hi, n;
    n = 0;
    case (w.kind)
      KIND_SAMPLE: begin
        servo_vel[0] = stick_rate(w.stick_lx, 0);
        servo_vel[1] = stick_rate(w.stick_ly, 1);
        servo_vel[2] = stick_rate(w.stick_rx, 2);
        servo_vel[3] = stick_rate(w.stick_ry, 3);
        servo_vel[4] = pair_rate(w.buttons[0], w.buttons[1], -1, 4);
        servo_vel[5] = pair_rate(w.buttons[2], w.buttons[3], -1, 5);
        servo_vel[6] = pair_rate(w.buttons[4], w.buttons[5], -1, 6);
        servo_vel[7] = pair_rate(w.buttons[6], w.buttons[7], 1, 7);
      end
      KIND_HOME: begin
        for (i = 0; i < N_SERVOS; i++) begin
          servo_pos[i] = pos_field(home_a, home_b, i);
          servo_vel[i] = 0;
        end
      end
      KIND_TICK: begin
        tick_count = (tick_count + 1) & 16'hFFFF;
        if (tick_count >= UPDATE_PERIOD_TICKS) begin
          tick_count = 0;
          for (i = 0; i < SERVO_COUNT; i++) begin
            if (servo_vel[i] == 0) continue;
            lo = pos_field(lower_a, lower_b, i);
            hi = pos_field(upper_a, upper_b, i);
            np = servo_pos[i] + servo_vel[i];
            if (np < lo) np = lo;
            else if (np > hi) np = hi;
            if (np == servo_pos[i]) begin
              servo_vel[i] = 0;
              continue;
            end
            servo_pos[i] = np & ((1 << POSITION_BITS) - 1);
            m.servo_id = 4'(i + 1);
            m.position = 10'(servo_pos[i]);
            m.last     = 1'b0;
            expected_moves.push_back(m);
            n++;
          end
          if (n > 0) begin
            m = expected_moves.pop_back();
            m.last = 1'b1;
            expected_moves.push_back(m);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_move(input out_word_t got);
    out_word_t want;
    if (expected_moves.size() == 0) begin
      $error("unexpected word: servo_id %0d position %0d last %0d",
             got.servo_id, got.position, got.last);
      failures++;
      return;
    end
    want = expected_moves.pop_front();
    if (got.servo_id !== want.servo_id) begin
      $error("servo_id mismatch: expected %0d, got %0d", want.servo_id, got.servo_id);
      failures++;
    end
    if (got.position !== want.position) begin
      $error("position mismatch: expected %0d, got %0d", want.position, got.position);
      failures++;
    end
    if (got.last !== want.last) begin
      $error("last mismatch: expected %0d, got %0d", want.last, got.last);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) check_move(out_data);
      if (in_valid && in_ready) begin
        words_taken++;
        predict_moves(in_data);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= $urandom_range(99) >= recv_idle_pct;
  end

  task automatic queue_word(input in_word_t w);
    pending_words.push_back(w);
    words_queued++;
    if (w.kind != KIND_UNUSED) items_queued++;
  endtask

  function automatic in_word_t random_word(logic [1:0] kind);
    in_word_t w;
    w.kind     = kind;
    w.stick_lx = 8'($urandom);
    w.stick_ly = 8'($urandom);
    w.stick_rx = 8'($urandom);
    w.stick_ry = 8'($urandom);
    w.buttons  = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t sample_word(logic [7:0] lx, logic [7:0] ly, logic [7:0] rx,
                                           logic [7:0] ry, logic [7:0] buttons);
    in_word_t w;
    w.kind     = KIND_SAMPLE;
    w.stick_lx = lx;
    w.stick_ly = ly;
    w.stick_rx = rx;
    w.stick_ry = ry;
    w.buttons  = buttons;
    return w;
  endfunction

  function automatic logic [7:0] stick_pick();
    case ($urandom_range(3))
      0:       return 8'($urandom);
      1:       return $urandom_range(1) ? 8'd255 : 8'd0;
      2:       return 8'($urandom_range(1) ? $urandom_range(255, 148) : $urandom_range(108, 0));
      default: return 8'($urandom_range(149, 107));
    endcase
  endfunction

  function automatic logic [PACK_W-1:0] rand_pack(int lo, int hi);
    logic [PACK_W-1:0] v;
    for (int i = 0; i < 4; i++) v[i * PACK_BITS +: PACK_BITS] = 10'($urandom_range(hi, lo));
    return v;
  endfunction

  task automatic queue_ticks(input int n);
    repeat (n) queue_word(random_word(KIND_TICK));
  endtask

  // sample then roughly one update interval of ticks, with occasional noise
  task automatic queue_jog_sequence();
    in_word_t w;
    int       ticks;
    if ($urandom_range(9) == 0) queue_word(random_word(KIND_HOME));
    w = sample_word(stick_pick(), stick_pick(), stick_pick(), stick_pick(), 8'($urandom));
    queue_word(w);
    ticks = $urandom_range(26, 14);
    repeat (ticks) begin
      if ($urandom_range(19) == 0) begin
        case ($urandom_range(2))
          0:       queue_word(random_word(KIND_UNUSED));
          1:       queue_word(random_word(KIND_SAMPLE));
          default: queue_word(random_word(KIND_HOME));
        endcase
      end
      queue_word(random_word(KIND_TICK));
    end
  endtask

  task automatic queue_random(input int count);
    int start;
    start = items_queued;
    while (items_queued - start < count) queue_jog_sequence();
  endtask

  task automatic wait_quiet(input int settle);
    int guard;
    guard = 0;
    while ((words_taken != words_queued || expected_moves.size() != 0) &&
           guard < QUIET_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (guard >= QUIET_LIMIT) begin
      $error("stalled with %0d words unsent and %0d results outstanding",
             words_queued - words_taken, expected_moves.size());
      failures++;
    end
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [PACK_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_LOWER_A: lower_a   = val;
      CFG_LOWER_B: lower_b   = val;
      CFG_UPPER_A: upper_a   = val;
      CFG_UPPER_B: upper_b   = val;
      CFG_HOME_A:  home_a    = val;
      CFG_HOME_B:  home_b    = val;
      CFG_REVERSE: rev_mask  = val[7:0];
      CFG_STEP:    step_size = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [PACK_W-1:0] lo_a, input logic [PACK_W-1:0] lo_b,
                           input logic [PACK_W-1:0] hi_a, input logic [PACK_W-1:0] hi_b,
                           input logic [PACK_W-1:0] hm_a, input logic [PACK_W-1:0] hm_b,
                           input logic [7:0] rev, input logic [STEP_W-1:0] step);
    write_register(CFG_LOWER_A, lo_a);
    write_register(CFG_LOWER_B, lo_b);
    write_register(CFG_UPPER_A, hi_a);
    write_register(CFG_UPPER_B, hi_b);
    write_register(CFG_HOME_A, hm_a);
    write_register(CFG_HOME_B, hm_b);
    // unused upper bits carry junk
    write_register(CFG_REVERSE, {32'($urandom), rev});
    write_register(CFG_STEP, {33'($urandom), step});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // defaults, positions still zero before the first home word
    @(posedge clk);
    queue_word(sample_word(8'd255, 8'd0, 8'd128, 8'd148, 8'h00));
    queue_ticks(UPDATE_PERIOD_TICKS);
    queue_word(random_word(KIND_HOME));
    queue_word(sample_word(8'd108, 8'd109, 8'd147, 8'd0, 8'h55));
    queue_word('1);
    queue_ticks(UPDATE_PERIOD_TICKS);
    queue_word(sample_word(8'd0, 8'd255, 8'd255, 8'd0, 8'hAA));
    queue_ticks(UPDATE_PERIOD_TICKS);
    // both buttons of every pair held
    queue_word(sample_word(8'd128, 8'd128, 8'd128, 8'd128, 8'hFF));
    queue_ticks(UPDATE_PERIOD_TICKS);
    // no mover at the update
    queue_word(sample_word(8'd128, 8'd127, 8'd129, 8'd128, 8'h00));
    queue_ticks(UPDATE_PERIOD_TICKS);
    wait_quiet(SETTLE_CYCLES);

    write_all(rand_pack(0, 300), rand_pack(0, 300), rand_pack(700, 1023),
              rand_pack(700, 1023), rand_pack(301, 699), rand_pack(301, 699),
              8'($urandom), 7'($urandom_range(127, 1)));
    @(posedge clk);
    queue_word(random_word(KIND_HOME));
    queue_random(55);
    wait_quiet(SETTLE_CYCLES);

    write_all({4{10'd0}}, {4{10'd0}}, {4{10'd1023}}, {4{10'd1023}},
              {4{10'd1023}}, {4{10'd0}}, 8'hFF, 7'd127);
    @(posedge clk);
    send_idle_pct = 65;
    recv_idle_pct = 20;
    queue_word(random_word(KIND_HOME));
    queue_random(55);
    wait_quiet(SETTLE_CYCLES);

    write_all(rand_pack(0, 1023), rand_pack(0, 1023), rand_pack(0, 1023),
              rand_pack(0, 1023), rand_pack(0, 1023), rand_pack(0, 1023),
              8'($urandom), 7'd0);
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(15);
    wait_quiet(SETTLE_CYCLES);

    // crossed limits are likely here
    write_all(rand_pack(0, 1023), rand_pack(0, 1023), rand_pack(0, 1023),
              rand_pack(0, 1023), rand_pack(0, 1023), rand_pack(0, 1023),
              8'($urandom), 7'($urandom_range(127, 1)));
    @(posedge clk);
    queue_word(random_word(KIND_HOME));
    queue_random(45);
    wait_quiet(SETTLE_CYCLES);

    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
